// ----- hdl/pulse_test_sequencer_top_defines.svh -----
// assertion macros for the pulse test sequencer
`ifndef PULSE_TEST_SEQUENCER_TOP_DEFINES_SVH
`define PULSE_TEST_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// plain property checked on every clock edge out of reset
`define PTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// overlapping implication checked on every clock edge out of reset
`define PTS_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// implication that must hold in the cycle after the antecedent
`define PTS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`else

`define PTS_ASSERT(lbl, prop, msg)
`define PTS_ASSERT_IMP(lbl, pre, post, msg)
`define PTS_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// ----- hdl/pts_pkg.sv -----
// types and codes shared by the pulse test sequencer modules
`timescale 1ns / 1ps

package pts_pkg;

	localparam int InTdataW  = 72;
	localparam int InTuserW  = 3;
	localparam int OutTdataW = 80;
	localparam int CfgIdxW   = 3;
	localparam int CfgDataW  = 32;

	typedef enum logic [1:0] {
		DEV_NONE   = 2'd0,
		DEV_IDLE   = 2'd1,
		DEV_ERROR  = 2'd2,
		DEV_ACTIVE = 2'd3
	} dev_state_t;

	typedef enum logic [2:0] {
		PH_NONE    = 3'd0,
		PH_PREPARE = 3'd1,
		PH_WSWITCH = 3'd2,
		PH_WOUTSET = 3'd3,
		PH_RUN     = 3'd4,
		PH_REQSTOP = 3'd5,
		PH_WDISC   = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		ACT_TICK    = 3'd0,
		ACT_ENABLE  = 3'd1,
		ACT_DISABLE = 3'd2,
		ACT_FCLEAR  = 3'd3,
		ACT_START   = 3'd4,
		ACT_STOP    = 3'd5,
		ACT_EXTFLT  = 3'd6,
		ACT_NOP     = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		PR_NONE   = 2'd0,
		PR_FORCED = 2'd1,
		PR_LIMIT  = 2'd2
	} problem_t;

	typedef enum logic [1:0] {
		OR_NONE = 2'd0,
		OR_OK   = 2'd1,
		OR_FAIL = 2'd2
	} op_result_t;

	typedef enum logic [1:0] {
		UE_NONE       = 2'd0,
		UE_NOT_READY  = 2'd1,
		UE_BLOCKED    = 2'd2,
		UE_BAD_CONFIG = 2'd3
	} user_error_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_TRANSIENT_DELAY = 3'd0,
		REG_PULSE_TIME      = 3'd1,
		REG_OUTPUT_MODE     = 3'd2,
		REG_OUTPUT_TYPE     = 3'd3,
		REG_VOLTAGE_LIMIT   = 3'd4,
		REG_CURRENT_LIMIT   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] transient_delay;
		logic [31:0] pulse_time;
		logic        output_mode;
		logic        output_type;
		logic [23:0] voltage_limit;
		logic [23:0] current_limit;
	} cfg_t;

	typedef struct packed {
		action_t     action;
		logic        params_valid;
		logic [23:0] sample_voltage;
		logic [23:0] sample_current;
		logic [15:0] fault_reason_in;
	} item_t;

	typedef struct packed {
		dev_state_t  main_state;
		phase_t      phase;
		logic [31:0] deadline_count;
		logic        deadline_armed;
		problem_t    problem_code;
		op_result_t  result_code;
		logic [23:0] volt_latch;
		logic [23:0] curr_latch;
		logic [15:0] fault_code;
		logic        lamp;
		logic        reg_running;
		problem_t    stop_cause;
		// copy of the registers taken at start
		logic [31:0] t_pulse;
		logic        t_mode;
		logic        t_type;
		logic [23:0] t_vlim;
		logic [23:0] t_ilim;
	} state_t;

	typedef struct packed {
		dev_state_t  dev_state;
		phase_t      sub_state;
		user_error_t user_error;
		logic        regulator_on;
		logic        led_on;
		logic        config_channels;
		logic        set_limits;
		op_result_t  op_result;
		problem_t    problem;
		logic [23:0] voltage_result;
		logic [23:0] current_result;
		logic [15:0] fault_reason;
	} result_t;

endpackage

// ----- hdl/pts_step.sv -----
// next-state and result logic for one command or tick
`timescale 1ns / 1ps

module pts_step import pts_pkg::*; (
	input  state_t  st,
	input  cfg_t    cfg,
	input  item_t   item,
	output state_t  st_next,
	output result_t res
);

	state_t      n;
	user_error_t uerr;
	logic        strobe_cfg;
	logic        strobe_lim;
	logic        expired;
	logic        trip;
	logic [31:0] count_dec;

	assign expired   = st.deadline_armed && (st.deadline_count == 32'd0);
	assign count_dec = st.deadline_count - 32'd1;
	assign trip      = st.t_type ? (item.sample_voltage > st.t_vlim)
	                             : (item.sample_current > st.t_ilim);

	always_comb begin
		n          = st;
		uerr       = UE_NONE;
		strobe_cfg = 1'b0;
		strobe_lim = 1'b0;

		case (item.action)
			ACT_TICK: begin
				if (st.main_state == DEV_ACTIVE) begin
					// waiting phases count the deadline down unless it has run out
					if (st.deadline_armed && !expired && (st.phase == PH_WSWITCH ||
					    st.phase == PH_WOUTSET || st.phase == PH_RUN ||
					    st.phase == PH_WDISC)) begin
						n.deadline_count = count_dec;
					end
					case (st.phase)
						PH_PREPARE: begin
							n.deadline_count = 32'(cfg.transient_delay);
							n.deadline_armed = 1'b1;
							strobe_cfg       = 1'b1;
							n.phase          = PH_WSWITCH;
						end
						PH_WSWITCH: begin
							if (expired) begin
								n.deadline_count = 32'(cfg.transient_delay);
								n.deadline_armed = 1'b1;
								strobe_lim       = 1'b1;
								n.phase          = PH_WOUTSET;
							end
						end
						PH_WOUTSET: begin
							if (expired) begin
								if (st.t_mode) begin
									n.deadline_count = st.t_pulse;
									n.deadline_armed = 1'b1;
								end else begin
									n.deadline_count = 32'd0;
									n.deadline_armed = 1'b0;
								end
								n.reg_running = 1'b1;
								n.phase       = PH_RUN;
							end
						end
						PH_RUN: begin
							// a limit trip on the same tick as the timeout wins
							if (expired || trip) begin
								n.stop_cause  = trip ? PR_LIMIT : PR_NONE;
								n.reg_running = 1'b0;
								n.lamp        = 1'b0;
								n.phase       = PH_REQSTOP;
							end
						end
						PH_REQSTOP: begin
							n.deadline_count = 32'(cfg.transient_delay);
							n.deadline_armed = 1'b1;
							n.phase          = PH_WDISC;
						end
						PH_WDISC: begin
							if (expired) begin
								if (st.stop_cause == PR_NONE) begin
									n.result_code = OR_OK;
									n.volt_latch  = item.sample_voltage;
									n.curr_latch  = item.sample_current;
								end else begin
									n.problem_code = st.stop_cause;
									n.result_code  = OR_FAIL;
								end
								n.main_state     = DEV_IDLE;
								n.phase          = PH_NONE;
								n.deadline_armed = 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ACT_ENABLE: begin
				if (st.main_state == DEV_NONE) begin
					n.main_state = DEV_IDLE;
					n.phase      = PH_NONE;
				end else if (st.main_state != DEV_IDLE) begin
					uerr = UE_NOT_READY;
				end
			end
			ACT_DISABLE, ACT_FCLEAR: begin
				if ((item.action == ACT_DISABLE && st.main_state == DEV_IDLE) ||
				    (item.action == ACT_FCLEAR && st.main_state == DEV_ERROR)) begin
					// back to none, regulator flag untouched
					n.fault_code   = 16'd0;
					n.problem_code = PR_NONE;
					n.result_code  = OR_NONE;
					n.volt_latch   = 24'd0;
					n.curr_latch   = 24'd0;
					n.lamp         = 1'b0;
					n.main_state   = DEV_NONE;
					n.phase        = PH_NONE;
				end else if (item.action == ACT_DISABLE && st.main_state != DEV_NONE) begin
					uerr = UE_BLOCKED;
				end
			end
			ACT_START: begin
				if (st.main_state == DEV_IDLE) begin
					if (item.params_valid) begin
						n.t_pulse      = cfg.pulse_time;
						n.t_mode       = cfg.output_mode;
						n.t_type       = cfg.output_type;
						n.t_vlim       = cfg.voltage_limit;
						n.t_ilim       = cfg.current_limit;
						n.fault_code   = 16'd0;
						n.problem_code = PR_NONE;
						n.result_code  = OR_NONE;
						n.volt_latch   = 24'd0;
						n.curr_latch   = 24'd0;
						n.main_state   = DEV_ACTIVE;
						n.phase        = PH_PREPARE;
						n.lamp         = 1'b1;
					end else begin
						uerr = UE_BAD_CONFIG;
					end
				end else begin
					uerr = UE_NOT_READY;
				end
			end
			ACT_STOP: begin
				if (st.main_state == DEV_ACTIVE) begin
					if (st.phase != PH_REQSTOP && st.phase != PH_WDISC) begin
						n.stop_cause  = (st.phase == PH_RUN) ? PR_NONE : PR_FORCED;
						n.reg_running = 1'b0;
						n.lamp        = 1'b0;
						n.phase       = PH_REQSTOP;
					end
				end else begin
					uerr = UE_BLOCKED;
				end
			end
			ACT_EXTFLT: begin
				n.main_state = DEV_ERROR;
				n.phase      = PH_NONE;
				n.fault_code = item.fault_reason_in;
			end
			default: begin
			end
		endcase
	end

	assign st_next = n;

	always_comb begin
		res.dev_state       = n.main_state;
		res.sub_state       = n.phase;
		res.user_error      = uerr;
		res.regulator_on    = n.reg_running;
		res.led_on          = n.lamp;
		res.config_channels = strobe_cfg;
		res.set_limits      = strobe_lim;
		res.op_result       = n.result_code;
		res.problem         = n.problem_code;
		res.voltage_result  = n.volt_latch;
		res.current_result  = n.curr_latch;
		res.fault_reason    = n.fault_code;
	end

endmodule

// ----- hdl/pulse_test_sequencer_top.sv -----
// pulse test sequencer: input stage, sequencer state, result register
//
// Commands and time ticks come in on the s_ stream, one item each. The kind of
// item (action) travels in s_tuser; params_valid, the two samples and the fault
// reason travel in s_tdata. Every accepted item gives exactly one result item
// on the m_ stream: the device state, sub-state, user error, lamp and regulator
// flags, the one-tick strobes and the latched outcome after that item.
// Configuration goes through cfg_we / cfg_index / cfg_wdata and is taken on
// any edge with cfg_we high; write it only while no item is in flight.
// An accepted item is registered in the input stage and then evaluated in one
// pass as it moves into the result register, where m_tvalid rises with its result.
// Throughput: one item per cycle while the result register is free or drained.
// When the receiver stalls, the result register holds and the input stage
// fills; s_tready drops once both are full and rises as soon as m_tready does.
// Reset puts the sequencer in state none with all outcomes cleared, the lamp
// and regulator off, transient delay 10 and all other registers 0.
`timescale 1ns / 1ps
`include "pulse_test_sequencer_top_defines.svh"

module pulse_test_sequencer_top import pts_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CfgIdxW-1:0]   cfg_index,
	input  logic [CfgDataW-1:0]  cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [0] params_valid, [24:1] sample_voltage, [48:25] sample_current,
	// [64:49] fault_reason_in, [71:65] zero
	input  logic [InTdataW-1:0]  s_tdata,
	// [2:0] action
	input  logic [InTuserW-1:0]  s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [1:0] dev_state, [4:2] sub_state, [6:5] user_error, [7] regulator_on,
	// [8] led_on, [9] config_channels, [10] set_limits, [12:11] op_result,
	// [14:13] problem, [38:15] voltage_result, [62:39] current_result,
	// [78:63] fault_reason, [79] zero
	output logic [OutTdataW-1:0] m_tdata
);

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	state_t  st_q;
	state_t  st_next;
	result_t res_next;
	result_t out_q;
	logic    out_valid_q;
	logic    adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// transient delay 10, everything else zero
			cfg_q <= {16'd10, 82'd0};
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_TRANSIENT_DELAY: cfg_q.transient_delay <= cfg_wdata[15:0];
				REG_PULSE_TIME:      cfg_q.pulse_time      <= cfg_wdata[31:0];
				REG_OUTPUT_MODE:     cfg_q.output_mode     <= cfg_wdata[0];
				REG_OUTPUT_TYPE:     cfg_q.output_type     <= cfg_wdata[0];
				REG_VOLTAGE_LIMIT:   cfg_q.voltage_limit   <= cfg_wdata[23:0];
				REG_CURRENT_LIMIT:   cfg_q.current_limit   <= cfg_wdata[23:0];
				default: begin
				end
			endcase
		end
	end

	// the stage moves into the result register when that is free or drained
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.action          <= action_t'(s_tuser[2:0]);
			item_s1.params_valid    <= s_tdata[0];
			item_s1.sample_voltage  <= s_tdata[24:1];
			item_s1.sample_current  <= s_tdata[48:25];
			item_s1.fault_reason_in <= s_tdata[64:49];
		end
	end

	pts_step u_step (
		.st      (st_q),
		.cfg     (cfg_q),
		.item    (item_s1),
		.st_next (st_next),
		.res     (res_next)
	);

	// all-zero state is state none, phase none, everything cleared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.fault_reason, out_q.current_result,
	                   out_q.voltage_result, out_q.problem, out_q.op_result,
	                   out_q.set_limits, out_q.config_channels, out_q.led_on,
	                   out_q.regulator_on, out_q.user_error, out_q.sub_state,
	                   out_q.dev_state};

	// a stalled result must freeze the sequencer state
	`PTS_ASSERT_NEXT(a_stall_holds_state, valid_s1 && out_valid_q && !m_tready, $stable(st_q), "state moved while result stalled")
	// an evaluated item always shows up as a result next cycle
	`PTS_ASSERT_NEXT(a_adv_gives_result, adv, m_tvalid, "evaluated item lost")
	// channel configure strobe only on entry to the switch settling phase
	`PTS_ASSERT_IMP(a_cfg_strobe_phase, m_tvalid && out_q.config_channels, out_q.sub_state == PH_WSWITCH && out_q.dev_state == DEV_ACTIVE, "configure strobe outside switch settling")

endmodule
